// ----- rtl/buvw_pkg.sv -----
// Package: constants, types and CORDIC table for the baseline uvw projection.
package buvw_pkg;

  localparam int unsigned Steps = 24;
  localparam int unsigned PhW = 34;  // CORDIC phase/residual width
  localparam int unsigned XyW = 34;  // CORDIC x/y width, Q30
  localparam logic signed [XyW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [26:0] PsPerMmQ24 = 27'sd55962769;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [PhW-1:0] z;
    logic                  neg;
  } cordic_t;

  function automatic logic signed [PhW-1:0] atan_lut(input logic [4:0] i);
    logic signed [PhW-1:0] r;
    case (i)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051E;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Range fold into [-90, 90) degrees before rotation.
  function automatic cordic_t cordic_init(input logic signed [15:0] ang);
    cordic_t c;
    logic signed [PhW-1:0] z;
    z = {{(PhW-32){ang[15]}}, ang, 16'h0000};
    c.neg = 1'b0;
    if (z >= 34'sh40000000) begin
      z = z - 34'sh80000000;
      c.neg = 1'b1;
    end else if (z < -34'sh40000000) begin
      z = z + 34'sh80000000;
      c.neg = 1'b1;
    end
    c.x = GainQ30;
    c.y = '0;
    c.z = z;
    return c;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] i);
    cordic_t r;
    logic signed [XyW-1:0] xs, ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    r = c;
    if (!c.z[PhW-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_lut(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_lut(i);
    end
    return r;
  endfunction

  // Q30 to Q15 with round half up, clamped to [-32768, 32768].
  function automatic logic signed [16:0] to_q15(input logic signed [XyW-1:0] v, input logic neg);
    logic signed [XyW:0] t;
    logic signed [XyW:0] r;
    t = neg ? -{v[XyW-1], v} : {v[XyW-1], v};
    r = (t + 35'sd16384) >>> 15;
    if (r > 35'sd32768) r = 35'sd32768;
    else if (r < -35'sd32768) r = -35'sd32768;
    return r[16:0];
  endfunction

endpackage

// ----- rtl/baseline_uvw_projection.sv -----
// Top level: baseline vector to u, v, w light delays, fully pipelined.
//
// One item in, one item out, accepting an item every cycle unless stalled.
// Its stages are 24 CORDIC stages, 1 trig product stage, 1 term stage,
// 1 sum stage, 1 scale stage and the output register. Both angles run
// through parallel 24-stage rotation-mode CORDICs; products are split so no
// multiply exceeds ~32x32 per stage. The whole pipe advances when the output
// register is empty or being drained, so a stall holds every stage in place.
module baseline_uvw_projection (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // hour_angle[15:0], declination[31:16], delta_x[55:32], delta_y[79:56],
  // delta_z[103:80]
  input  logic [103:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // u_delay[25:0], v_delay[51:26], w_delay[77:52], zero fill [79:78]
  output logic [79:0] m_tdata
);

  localparam int unsigned NS = buvw_pkg::Steps;

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // CORDIC pipe
  buvw_pkg::cordic_t ch [0:NS];
  buvw_pkg::cordic_t cd [0:NS];
  logic signed [23:0] dx [0:NS];
  logic signed [23:0] dy [0:NS];
  logic signed [23:0] dz [0:NS];
  logic vld [0:NS];

  assign ch[0] = buvw_pkg::cordic_init(s_tdata[15:0]);
  assign cd[0] = buvw_pkg::cordic_init(s_tdata[31:16]);
  assign dx[0] = s_tdata[55:32];
  assign dy[0] = s_tdata[79:56];
  assign dz[0] = s_tdata[103:80];
  assign vld[0] = s_tvalid;

  for (genvar g = 0; g < NS; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (adv) begin
        vld[g+1] <= vld[g];
      end
      if (adv) begin
        ch[g+1] <= buvw_pkg::cordic_step(ch[g], 5'(g));
        cd[g+1] <= buvw_pkg::cordic_step(cd[g], 5'(g));
        dx[g+1] <= dx[g];
        dy[g+1] <= dy[g];
        dz[g+1] <= dz[g];
      end
    end
  end

  logic signed [16:0] sh, chh, sd, cdd;
  assign chh = buvw_pkg::to_q15(ch[NS].x, ch[NS].neg);
  assign sh  = buvw_pkg::to_q15(ch[NS].y, ch[NS].neg);
  assign cdd = buvw_pkg::to_q15(cd[NS].x, cd[NS].neg);
  assign sd  = buvw_pkg::to_q15(cd[NS].y, cd[NS].neg);

  // Stage A: trig cross products and single-trig terms (Q15 x mm).
  logic signed [33:0] sdch, sdsh, cdch, cdsh;  // Q30
  logic signed [40:0] u1, u2, vz, wz;          // mm * Q15
  logic signed [23:0] dxa, dya, dza;
  logic va;
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (adv) va <= vld[NS];
    if (adv) begin
      sdch <= sd * chh;
      sdsh <= sd * sh;
      cdch <= cdd * chh;
      cdsh <= cdd * sh;
      u1 <= dx[NS] * sh;
      u2 <= dy[NS] * chh;
      vz <= dz[NS] * cdd;
      wz <= dz[NS] * sd;
      dxa <= dx[NS];
      dya <= dy[NS];
      dza <= dz[NS];
    end
  end

  // Stage B: double-trig terms in Q30 mm, and the u sum in Q15 mm.
  logic signed [57:0] tv1, tv2, tw1, tw2;
  logic signed [41:0] uq;
  logic signed [40:0] vzb, wzb;
  logic vb;
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (adv) vb <= va;
    if (adv) begin
      tv1 <= dxa * sdch;
      tv2 <= dya * sdsh;
      tw1 <= dxa * cdch;
      tw2 <= dya * cdsh;
      uq  <= 42'(u1) + 42'(u2);
      vzb <= vz;
      wzb <= wz;
    end
  end

  // Stage C: sums in Q30, rounded to Q8.
  logic signed [60:0] su, sv, sw;
  assign su = 61'(uq) <<< 15;
  assign sv = -61'(tv1) + 61'(tv2) + (61'(vzb) <<< 15);
  assign sw =  61'(tw1) - 61'(tw2) + (61'(wzb) <<< 15);

  logic signed [38:0] au, av, aw;  // Q8 mm
  logic vc;
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (adv) vc <= vb;
    if (adv) begin
      au <= 39'((su + 61'sd2097152) >>> 22);
      av <= 39'((sv + 61'sd2097152) >>> 22);
      aw <= 39'((sw + 61'sd2097152) >>> 22);
    end
  end

  // Stage D: scale by ps per mm, split into high/low partial products.
  logic signed [38:0] pl_u, pl_v, pl_w;  // low 12 bits x const
  logic signed [53:0] ph_u, ph_v, ph_w;  // high part x const
  logic vd;
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else if (adv) vd <= vc;
    if (adv) begin
      pl_u <= $signed({1'b0, au[11:0]}) * buvw_pkg::PsPerMmQ24;
      pl_v <= $signed({1'b0, av[11:0]}) * buvw_pkg::PsPerMmQ24;
      pl_w <= $signed({1'b0, aw[11:0]}) * buvw_pkg::PsPerMmQ24;
      ph_u <= $signed(au[38:12]) * buvw_pkg::PsPerMmQ24;
      ph_v <= $signed(av[38:12]) * buvw_pkg::PsPerMmQ24;
      ph_w <= $signed(aw[38:12]) * buvw_pkg::PsPerMmQ24;
    end
  end

  function automatic logic signed [25:0] fin(input logic signed [53:0] h,
                                             input logic signed [38:0] l);
    logic signed [67:0] p;
    logic signed [67:0] r;
    p = (68'(h) <<< 12) + 68'(l) + 68'sh80000000;
    r = p >>> 32;
    if (r > 68'sd33554431) r = 68'sd33554431;
    else if (r < -68'sd33554432) r = -68'sd33554432;
    return r[25:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= vd;
    if (adv) begin
      m_tdata <= {2'b00, fin(ph_w, pl_w), fin(ph_v, pl_v), fin(ph_u, pl_u)};
    end
  end

  // Checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while stalled");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("pipe stalled with empty output");

endmodule

// ----- tb/tb_baseline_uvw_projection.sv -----
// Testbench for the baseline uvw projection: directed and random baselines, self-checking.
module tb_baseline_uvw_projection;

  // Phase units of the fold and the CORDIC: 2^31 is 180 degrees.
  localparam longint HalfTurn    = 64'sd2147483648;
  localparam longint QuarterTurn = 64'sd1073741824;
  localparam longint GainQ30     = 64'sd652032874;
  localparam longint PsPerMmQ24  = 64'sd55962769;
  localparam longint DelayMax    = 64'sd33554431;
  localparam longint DelayMin    = -64'sd33554432;
  localparam int     WatchLimit  = 2000;
  localparam int     DrainCycles = 64;

  typedef struct packed {
    logic signed [23:0] dz;
    logic signed [23:0] dy;
    logic signed [23:0] dx;
    logic signed [15:0] dec;
    logic signed [15:0] ha;
  } baseline_t;

  typedef struct packed {
    logic [1:0]         fill;
    logic signed [25:0] w;
    logic signed [25:0] v;
    logic signed [25:0] u;
  } delays_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [103:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  baseline_uvw_projection dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  delays_t pending_delays[$];
  int      mismatches = 0;
  bit      steady = 1'b0;   // long stretch with no idling on either side
  int      idle_cycles = 0;

  // Fixed-point sine/cosine in Q15, same fold, table and rounding as the block.
  function automatic longint round_q15(longint q30);
    longint r;
    r = (q30 + 16384) >>> 15;
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint arctan_step(int i);
    longint t[24];
    t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
          64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
          64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
          64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
          64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  function automatic void angle_sincos(input logic signed [15:0] ang, output longint s,
                                       output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang) * 65536;
    x = GainQ30;
    y = 0;
    flip = 1'b0;
    if (z >= QuarterTurn) begin
      z -= HalfTurn; flip = 1'b1;
    end else if (z < -QuarterTurn) begin
      z += HalfTurn; flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = round_q15(x);
    s = round_q15(y);
  endfunction

  // Q30 mm to saturated ps. Q8 times Q24 stays inside 64 bits for these ranges.
  function automatic logic signed [25:0] mm_to_ps(longint q30);
    longint a8, r;
    a8 = (q30 + (64'sd1 <<< 21)) >>> 22;
    r = (a8 * PsPerMmQ24 + (64'sd1 <<< 31)) >>> 32;
    if (r > DelayMax) r = DelayMax;
    if (r < DelayMin) r = DelayMin;
    return r[25:0];
  endfunction

  function automatic delays_t project_baseline(baseline_t b);
    longint sh, ch, sd, cd, dx, dy, dz;
    delays_t d;
    angle_sincos(b.ha, sh, ch);
    angle_sincos(b.dec, sd, cd);
    dx = b.dx; dy = b.dy; dz = b.dz;
    d.fill = '0;
    d.u = mm_to_ps(dx * sh * 32768 + dy * ch * 32768);
    d.v = mm_to_ps(-dx * sd * ch + dy * sd * sh + dz * cd * 32768);
    d.w = mm_to_ps(dx * cd * ch - dy * cd * sh + dz * sd * 32768);
    return d;
  endfunction

  // Sender: random gaps; valid stays up between back-to-back items.
  task automatic send_baseline(baseline_t b);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_delays.push_back(project_baseline(b));
  endtask

  task automatic send_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic baseline_t random_baseline();
    baseline_t b;
    b = 104'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(3))
      0: begin   // short baselines, no saturation
        b.dx = $signed(b.dx) >>> $urandom_range(16, 4);
        b.dy = $signed(b.dy) >>> $urandom_range(16, 4);
        b.dz = $signed(b.dz) >>> $urandom_range(16, 4);
      end
      1: begin   // angles near the fold points
        b.ha  = {$urandom_range(3) == 0 ? 2'b11 : 2'b01, 14'h0} + $signed(5'($urandom));
        b.dec = {$urandom_range(1) ? 2'b10 : 2'b11, 14'h0} + $signed(5'($urandom));
      end
      default: ;
    endcase
    return b;
  endfunction

  // Receiver: random stalls, checks each accepted result.
  always @(posedge clk) begin
    delays_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_delays.size() == 0) begin
          $display("%0t: unexpected result u=%0d v=%0d w=%0d", $time, got.u, got.v, got.w);
          mismatches++;
        end else begin
          want = pending_delays.pop_front();
          if (got.u !== want.u) begin
            $display("%0t: u_delay expected %0d got %0d", $time, want.u, got.u);
            mismatches++;
          end
          if (got.v !== want.v) begin
            $display("%0t: v_delay expected %0d got %0d", $time, want.v, got.v);
            mismatches++;
          end
          if (got.w !== want.w) begin
            $display("%0t: w_delay expected %0d got %0d", $time, want.w, got.w);
            mismatches++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= 28);
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_delays.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every angle fold point and saturation.
  task automatic test_extremes();
    logic signed [15:0] angs[8];
    logic signed [23:0] mags[4];
    baseline_t b;
    angs = '{16'sh8000, 16'shC000, 16'shBFFF, 16'sh0000, 16'sh3FFF, 16'sh4000,
             16'sh7FFF, 16'sh2000};
    mags = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, -24'sd1};
    for (int i = 0; i < 8; i++) begin
      b.ha = angs[i]; b.dec = angs[7 - i];
      b.dx = mags[i % 4]; b.dy = mags[(i + 1) % 4]; b.dz = mags[(i + 2) % 4];
      send_baseline(b);
    end
    for (int i = 0; i < 8; i++) begin
      b.ha = angs[(i * 3) % 8]; b.dec = angs[i];
      b.dx = (i & 1) ? 24'sh7FFFFF : 24'sh800000;
      b.dy = (i & 2) ? 24'sh7FFFFF : 24'sh800000;
      b.dz = (i & 4) ? 24'sh7FFFFF : 24'sh800000;
      send_baseline(b);
    end
    // Small vectors exercise rounding ties rather than saturation.
    for (int i = 0; i < 6; i++) begin
      b.ha = angs[i]; b.dec = angs[i + 2];
      b.dx = 24'(i); b.dy = 24'(-i); b.dz = 24'sd1 <<< i;
      send_baseline(b);
    end
    send_quiet();
  endtask

  // Full random stream, with one full pause until the pipe drains.
  task automatic test_random_stream();
    for (int n = 0; n < 650; n++) begin
      if (n == 200) begin
        send_quiet();
        wait_drained();
      end
      steady = (n >= 400 && n < 500);
      send_baseline(random_baseline());
    end
    steady = 1'b0;
    send_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random_stream();
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_delays.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/buvw_pkg.sv
rtl/baseline_uvw_projection.sv
tb/tb_baseline_uvw_projection.sv
